[hw/rtl/npcs_pkg.sv]
// Shared types and constants for the nearest palette color search block.
// Used by npcs_palette_mem, npcs_dist_pipe and nearest_palette_color_search.
`default_nettype none
package npcs_pkg;

	localparam int CH_W      = 8;   // one color channel
	localparam int ENTRY_W   = 24;  // packed RGB entry
	localparam int PAL_IDX_W = 8;   // palette index field
	localparam int SQ_W      = 16;  // square of a channel difference
	localparam int DIST_W    = 26;  // weighted distance, scaled by 1000
	localparam int SIZE_W    = 9;   // palette_size register

	// Luma weights scaled by 1000
	localparam logic [9:0] W_RED   = 10'd299;
	localparam logic [9:0] W_GREEN = 10'd587;
	localparam logic [9:0] W_BLUE  = 10'd114;

	localparam logic [DIST_W-1:0] MAX_DIST   = 26'd65025000;
	localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd256;

	// Request opcodes
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
	} rgb_t;

	// Sideband that travels with each palette read down the pipeline
	typedef struct packed {
		logic                 valid;
		logic                 last;
		logic [PAL_IDX_W-1:0] idx;
	} tag_t;

endpackage
`default_nettype wire

[hw/rtl/npcs_palette_mem.sv]
// Palette storage: one write port, one read port, registered read data.
// Depends on npcs_pkg for the entry type.
`default_nettype none
module npcs_palette_mem #(
	parameter int DEPTH = 256,
	parameter int AW    = 8
) (
	input  wire                 clk,
	input  wire                 wr_en,
	input  wire [AW-1:0]        wr_addr,
	input  npcs_pkg::rgb_t      wr_data,
	input  wire                 rd_en,
	input  wire [AW-1:0]        rd_addr,
	output npcs_pkg::rgb_t      rd_data
);
	import npcs_pkg::*;

	rgb_t mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read port, registered read data
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

[hw/rtl/npcs_dist_pipe.sv]
// Weighted squared distance pipeline: squares, weighted products, sum.
// Depends on npcs_pkg for widths, weights and the tag type.
`default_nettype none
module npcs_dist_pipe (
	input  wire                           clk,
	input  wire                           arst_n,
	input  npcs_pkg::tag_t                tag_s1,
	input  npcs_pkg::rgb_t                entry_s1,
	input  npcs_pkg::rgb_t                target,
	output npcs_pkg::tag_t                tag_s4,
	output logic [npcs_pkg::DIST_W-1:0]   dist_s4
);
	import npcs_pkg::*;

	logic [CH_W-1:0]   dr, dg, db;
	logic [SQ_W-1:0]   sq_r_s2, sq_g_s2, sq_b_s2;
	logic [DIST_W-1:0] pr_s3, pg_s3, pb_s3;
	tag_t              tag_s2, tag_s3;

	// Absolute channel differences
	assign dr = (entry_s1.red   >= target.red)   ? entry_s1.red   - target.red
	                                               : target.red   - entry_s1.red;
	assign dg = (entry_s1.green >= target.green) ? entry_s1.green - target.green
	                                               : target.green - entry_s1.green;
	assign db = (entry_s1.blue  >= target.blue)  ? entry_s1.blue  - target.blue
	                                               : target.blue  - entry_s1.blue;

	// Tag pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2 <= '0;
			tag_s3 <= '0;
			tag_s4 <= '0;
		end else begin
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
			tag_s4 <= tag_s3;
		end
	end

	// Datapath stages
	always_ff @(posedge clk) begin
		// s2: squares
		sq_r_s2 <= SQ_W'(dr) * SQ_W'(dr);
		sq_g_s2 <= SQ_W'(dg) * SQ_W'(dg);
		sq_b_s2 <= SQ_W'(db) * SQ_W'(db);
		// s3: constant weights
		pr_s3   <= DIST_W'(sq_r_s2) * DIST_W'(W_RED);
		pg_s3   <= DIST_W'(sq_g_s2) * DIST_W'(W_GREEN);
		pb_s3   <= DIST_W'(sq_b_s2) * DIST_W'(W_BLUE);
		// s4: sum, always below 2^26
		dist_s4 <= pr_s3 + pg_s3 + pb_s3;
	end

endmodule
`default_nettype wire

[hw/rtl/nearest_palette_color_search.sv]
// Top level: request handling, palette scan sequencer and running minimum.
// Depends on npcs_pkg, npcs_palette_mem and npcs_dist_pipe.
// A query over n entries reads each entry in turn and runs it through the distance
// pipeline, then loads the result slot; an empty palette goes straight to the result.
// Writes are taken every cycle while idle with no config write pending; after a query no new
// request is taken until its result is handed off. Reset: palette_size is 256, the palette is kept.
`default_nettype none
module nearest_palette_color_search #(
	parameter int PALETTE_DEPTH = 256
) (
	input  wire                                clk,
	input  wire                                arst_n,
	// request channel
	input  wire                                in_valid,
	output logic                               in_ready,
	input  wire                                op,
	input  wire [7:0]                          entry_index,
	input  wire [7:0]                          entry_red,
	input  wire [7:0]                          entry_green,
	input  wire [7:0]                          entry_blue,
	input  wire [7:0]                          target_red,
	input  wire [7:0]                          target_green,
	input  wire [7:0]                          target_blue,
	// result channel
	output logic                               out_valid,
	input  wire                                out_ready,
	output logic [7:0]                         best_index,
	output logic [25:0]                        best_distance,
	// configuration channel
	input  wire                                cfg_valid,
	output logic                               cfg_ready,
	input  wire [8:0]                          cfg_data
);
	import npcs_pkg::*;

	localparam int AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
	localparam int CW = $clog2(PALETTE_DEPTH + 1);
	localparam logic [SIZE_W-1:0] DEPTH_SZ = SIZE_W'(PALETTE_DEPTH);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	state_t               state_q;
	logic [SIZE_W-1:0]    size_q;
	logic [CW-1:0]        n_q;
	logic [AW-1:0]        rd_addr_q;
	rgb_t                 target_q;
	logic                 have_q;
	logic [PAL_IDX_W-1:0] best_idx_q;
	logic [DIST_W-1:0]    best_d_q;
	logic                 out_valid_q;
	logic [PAL_IDX_W-1:0] out_idx_q;
	logic [DIST_W-1:0]    out_d_q;

	logic                 in_acc;
	logic                 wr_en;
	logic                 rd_en;
	logic                 last_rd;
	logic [SIZE_W-1:0]    eff_size;
	rgb_t                 wr_data;
	rgb_t                 rd_data;
	tag_t                 rd_tag;
	tag_t                 tag_s1;
	tag_t                 tag_s4;
	logic [DIST_W-1:0]    dist_s4;
	logic                 take_new;
	logic                 hand_off;

	// A pending config write goes first, so a query never sees a size changing under it
	assign in_ready  = (state_q == ST_IDLE) && !cfg_valid;
	assign cfg_ready = (state_q == ST_IDLE);
	assign in_acc    = in_valid && in_ready;

	// Palette write: out-of-range slots are dropped
	assign wr_en   = in_acc && (op == OP_WRITE) && ({1'b0, entry_index} < DEPTH_SZ);
	assign wr_data = '{red: entry_red, green: entry_green, blue: entry_blue};

	// Search length saturates at the palette depth
	assign eff_size = (size_q > DEPTH_SZ) ? DEPTH_SZ : size_q;

	// Read issue during the scan
	assign rd_en       = (state_q == ST_SCAN);
	assign last_rd     = (CW'(rd_addr_q) == (n_q - CW'(1)));
	assign rd_tag.valid = rd_en;
	assign rd_tag.last  = last_rd;
	assign rd_tag.idx   = PAL_IDX_W'(rd_addr_q);

	// New distance beats the running best (first one always wins)
	assign take_new = tag_s4.valid && (!have_q || (dist_s4 < best_d_q));

	// Hand off once the result slot is free
	assign hand_off = (state_q == ST_FINISH) && (!out_valid_q || out_ready);

	npcs_palette_mem #(
		.DEPTH (PALETTE_DEPTH),
		.AW    (AW)
	) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (entry_index[AW-1:0]),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr_q),
		.rd_data (rd_data)
	);

	// Tag follows the memory read latency
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
		end else begin
			tag_s1 <= rd_tag;
		end
	end

	npcs_dist_pipe u_dist (
		.clk      (clk),
		.arst_n   (arst_n),
		.tag_s1   (tag_s1),
		.entry_s1 (rd_data),
		.target   (target_q),
		.tag_s4   (tag_s4),
		.dist_s4  (dist_s4)
	);

	// Sequencer, running minimum and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			size_q      <= SIZE_RESET;
			n_q         <= '0;
			rd_addr_q   <= '0;
			have_q      <= 1'b0;
			best_idx_q  <= '0;
			best_d_q    <= '0;
			out_valid_q <= 1'b0;
			out_idx_q   <= '0;
			out_d_q     <= '0;
			target_q    <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				size_q <= cfg_data;
			end
			// result slot: load a finished query, or free it once taken
			if (hand_off) begin
				out_valid_q <= 1'b1;
				out_idx_q   <= best_idx_q;
				out_d_q     <= best_d_q;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (take_new) begin
				have_q     <= 1'b1;
				best_idx_q <= tag_s4.idx;
				best_d_q   <= dist_s4;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc && (op == OP_QUERY)) begin
						target_q  <= '{red: target_red, green: target_green,
						               blue: target_blue};
						have_q    <= 1'b0;
						n_q       <= CW'(eff_size);
						rd_addr_q <= '0;
						if (eff_size == '0) begin
							best_idx_q <= '0;
							best_d_q   <= '0;
							state_q    <= ST_FINISH;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					rd_addr_q <= AW'(rd_addr_q + 1'b1);
					if (last_rd) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (tag_s4.valid && tag_s4.last) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (hand_off) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign best_index    = out_idx_q;
	assign best_distance = out_d_q;

`ifndef SYNTHESIS
	// Palette writes never overlap a scan
	a_no_write_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (state_q == ST_IDLE))
		else $error("palette written during a scan");

	// Distances only come out of the pipeline while a query is in flight
	a_pipe_in_query: assert property (@(posedge clk) disable iff (!arst_n)
		tag_s4.valid |-> (state_q == ST_SCAN || state_q == ST_DRAIN))
		else $error("distance arrived outside a query");

	// Scan address stays below the search length
	a_addr_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (CW'(rd_addr_q) < n_q))
		else $error("scan address beyond search length");

	// A finished query whose slot is free shows its result next cycle
	a_finish_handoff: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINISH && (!out_valid_q || out_ready)) |=>
		(out_valid_q && state_q == ST_IDLE))
		else $error("finished result not handed off");

	// Reported distance stays within the weighted maximum
	a_dist_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_d_q <= MAX_DIST))
		else $error("distance out of range");
`endif

endmodule
`default_nettype wire

[tb/npcs_checker.sv]
`timescale 1ns / 1ps
// Result checker for nearest_palette_color_search: mirrors the palette and the search
// size from the request and config traffic, predicts each query result and compares it.
// Depends on npcs_pkg.
module npcs_checker
	import npcs_pkg::*;
#(
	parameter int PALETTE_DEPTH = 256
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	input  wire                 in_ready,
	input  wire                 op,
	input  wire [7:0]           entry_index,
	input  wire [7:0]           entry_red,
	input  wire [7:0]           entry_green,
	input  wire [7:0]           entry_blue,
	input  wire [7:0]           target_red,
	input  wire [7:0]           target_green,
	input  wire [7:0]           target_blue,
	input  wire                 out_valid,
	input  wire                 out_ready,
	input  wire [7:0]           best_index,
	input  wire [25:0]          best_distance,
	input  wire                 cfg_valid,
	input  wire                 cfg_ready,
	input  wire [8:0]           cfg_data,
	output int                  errors,
	output int                  pending
);

	typedef struct packed {
		logic [PAL_IDX_W-1:0] index;
		logic [DIST_W-1:0]    distance;
	} nearest_t;

	rgb_t              palette [PALETTE_DEPTH];
	logic [SIZE_W-1:0] search_size;
	nearest_t          nearest_q [$];
	nearest_t          want;
	int                fail_tally;

	function automatic int unsigned chan_sq(logic [CH_W-1:0] a, logic [CH_W-1:0] b);
		int unsigned d;
		d = (a >= b) ? a - b : b - a;
		return d * d;
	endfunction

	// Scan the first search_size entries (capped at the palette depth), keep the first strictly smallest distance
	function automatic nearest_t find_nearest(rgb_t tgt);
		nearest_t    best;
		int unsigned span;
		int unsigned d;
		best = '0;
		span = (search_size > PALETTE_DEPTH) ? PALETTE_DEPTH : search_size;
		for (int unsigned i = 0; i < span; i++) begin
			d = W_RED * chan_sq(palette[i].red, tgt.red)
			  + W_GREEN * chan_sq(palette[i].green, tgt.green)
			  + W_BLUE * chan_sq(palette[i].blue, tgt.blue);
			if (i == 0 || d < best.distance) begin
				best.index    = i[PAL_IDX_W-1:0];
				best.distance = d[DIST_W-1:0];
			end
			// nothing beats an exact match
			if (best.distance == 0)
				break;
		end
		return best;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			search_size = SIZE_RESET;
			nearest_q.delete();
			fail_tally = 0;
			errors  <= 0;
			pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready)
				search_size = cfg_data;

			// request side: writes update the mirror, queries queue a prediction
			if (in_valid && in_ready) begin
				if (op == OP_WRITE) begin
					if (entry_index < PALETTE_DEPTH)
						palette[entry_index] = {entry_red, entry_green, entry_blue};
				end else begin
					nearest_q.push_back(find_nearest({target_red, target_green, target_blue}));
				end
			end

			// result side: compare against the oldest prediction
			if (out_valid && out_ready) begin
				if (nearest_q.size() == 0) begin
					$display("%0t ERROR result with no query outstanding: index %0d distance %0d",
						$time, best_index, best_distance);
					fail_tally++;
				end else begin
					want = nearest_q.pop_front();
					if (best_index !== want.index) begin
						$display("%0t ERROR best_index: expected %0d, actual %0d",
							$time, want.index, best_index);
						fail_tally++;
					end
					if (best_distance !== want.distance) begin
						$display("%0t ERROR best_distance: expected %0d, actual %0d",
							$time, want.distance, best_distance);
						fail_tally++;
					end
				end
			end

			pending <= nearest_q.size();
			errors  <= fail_tally;
		end
	end

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// Testbench top for nearest_palette_color_search: clock, reset, request and config
// stimulus, result back-pressure and the verdict. Depends on npcs_pkg and npcs_checker.
module tb;
	import npcs_pkg::*;

	localparam int DEPTH        = 256;
	localparam int CYCLE_LIMIT  = 3000000;
	localparam int RANDOM_ITEMS = 1650;

	logic        clk          = 1'b0;
	logic        arst_n       = 1'b0;
	logic        in_valid     = 1'b0;
	logic        in_ready;
	logic        op           = OP_WRITE;
	logic [7:0]  entry_index  = '0;
	logic [7:0]  entry_red    = '0;
	logic [7:0]  entry_green  = '0;
	logic [7:0]  entry_blue   = '0;
	logic [7:0]  target_red   = '0;
	logic [7:0]  target_green = '0;
	logic [7:0]  target_blue  = '0;
	logic        out_valid;
	logic        out_ready    = 1'b0;
	logic [7:0]  best_index;
	logic [25:0] best_distance;
	logic        cfg_valid    = 1'b0;
	logic        cfg_ready;
	logic [8:0]  cfg_data     = '0;

	int   errors;
	int   pending;
	int   cycle_count = 0;
	bit   steady = 1'b0;   // no idling on either side in this phase
	bit   narrow = 1'b0;   // colors from a few corner values, to force ties
	rgb_t shadow [DEPTH];  // what has been written, for picking targets
	int   span;            // entries a query currently searches
	int   n_writes   = 0;
	int   n_queries  = 0;
	int   n_settings = 0;

	nearest_palette_color_search #(.PALETTE_DEPTH(DEPTH)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .op(op), .entry_index(entry_index),
		.entry_red(entry_red), .entry_green(entry_green), .entry_blue(entry_blue),
		.target_red(target_red), .target_green(target_green), .target_blue(target_blue),
		.out_valid(out_valid), .out_ready(out_ready),
		.best_index(best_index), .best_distance(best_distance),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	npcs_checker #(.PALETTE_DEPTH(DEPTH)) chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .op(op), .entry_index(entry_index),
		.entry_red(entry_red), .entry_green(entry_green), .entry_blue(entry_blue),
		.target_red(target_red), .target_green(target_green), .target_blue(target_blue),
		.out_valid(out_valid), .out_ready(out_ready),
		.best_index(best_index), .best_distance(best_distance),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.errors(errors), .pending(pending)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Run guard
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Mostly short gaps, a few long ones
	function automatic int idle_cycles();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [7:0] corner();
		case ($urandom_range(0, 3))
			0: return 8'd0;
			1: return 8'd1;
			2: return 8'd254;
			default: return 8'd255;
		endcase
	endfunction

	function automatic rgb_t pick_color();
		rgb_t c;
		c.red   = $urandom;
		c.green = $urandom;
		c.blue  = $urandom;
		if (narrow) begin
			c.red   = corner();
			c.green = corner();
			c.blue  = corner();
		end
		return c;
	endfunction

	// Offer one request and hold it until accepted
	task automatic send_request(input logic kind, input logic [7:0] slot,
			input rgb_t ent, input rgb_t tgt);
		int gap;
		gap = idle_cycles();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		op           <= kind;
		entry_index  <= slot;
		entry_red    <= ent.red;
		entry_green  <= ent.green;
		entry_blue   <= ent.blue;
		target_red   <= tgt.red;
		target_green <= tgt.green;
		target_blue  <= tgt.blue;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		if (kind == OP_WRITE) begin
			shadow[slot] = ent;
			n_writes++;
		end else begin
			n_queries++;
		end
	endtask

	task automatic write_entry(input logic [7:0] slot, input rgb_t ent);
		send_request(OP_WRITE, slot, ent, pick_color());
	endtask

	task automatic query(input rgb_t tgt);
		send_request(OP_QUERY, $urandom, pick_color(), tgt);
	endtask

	// Stop offering and wait for every predicted result, then a tail
	task automatic drain(input int tail);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (tail) @(posedge clk);
	endtask

	// palette_size is only changed with the block idle
	task automatic set_size(input logic [8:0] value);
		drain(12);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		span = (value > DEPTH) ? DEPTH : value;
		n_settings++;
	endtask

	// Writes land mostly inside the searched range; some queries hit an entry exactly
	task automatic random_request();
		rgb_t c;
		int   pick;
		pick = $urandom_range(0, 99);
		c = pick_color();
		if (pick < 45) begin
			if ($urandom_range(0, 4) == 0)
				c = shadow[$urandom_range(0, DEPTH - 1)];
			if (span > 0 && $urandom_range(0, 9) < 7)
				write_entry($urandom_range(0, span - 1), c);
			else
				write_entry($urandom, c);
		end else begin
			if (span > 0 && $urandom_range(0, 9) < 3)
				c = shadow[$urandom_range(0, span - 1)];
			query(c);
		end
	endtask

	// Result side: random ready gaps plus one long hold-off
	initial begin
		int gap;
		int results_seen;
		bit held;
		results_seen = 0;
		held = 1'b0;
		wait (arst_n);
		forever begin
			if (!held && results_seen >= 60) begin
				held = 1'b1;
				out_ready <= 1'b0;
				repeat (600) @(posedge clk);
			end
			gap = idle_cycles();
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			results_seen++;
		end
	end

	// Request side and verdict
	initial begin
		int i;
		int phase;
		int size_pick;
		int budget;
		int done_random;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		span = DEPTH;

		// empty palette
		set_size(9'd0);
		query({8'd0, 8'd0, 8'd0});
		query({8'd255, 8'd255, 8'd255});

		// small palette with a duplicated entry
		write_entry(8'd0, {8'd0, 8'd0, 8'd0});
		write_entry(8'd1, {8'd255, 8'd255, 8'd255});
		write_entry(8'd2, {8'd0, 8'd0, 8'd0});
		write_entry(8'd3, {8'd128, 8'd64, 8'd200});

		// single entry, farthest possible target
		set_size(9'd1);
		query({8'd255, 8'd255, 8'd255});

		// exact matches, a tie between two entries, a near miss
		set_size(9'd4);
		query({8'd0, 8'd0, 8'd0});
		query({8'd255, 8'd255, 8'd255});
		query({8'd1, 8'd0, 8'd0});
		query({8'd128, 8'd64, 8'd200});
		query({8'd127, 8'd65, 8'd201});

		// fill the whole palette before any wider search
		for (i = 0; i < DEPTH; i++)
			write_entry(i[7:0], pick_color());

		// oversized search saturates to the full palette
		set_size(9'd511);
		query(pick_color());
		query(shadow[DEPTH - 1]);
		set_size(9'd256);
		query(shadow[200]);
		query(pick_color());

		// random phases, each with its own palette_size
		done_random = 0;
		phase = 0;
		while (done_random < RANDOM_ITEMS) begin
			case (phase)
				0: size_pick = 0;
				1: size_pick = 256;
				2: size_pick = 511;
				3: size_pick = 1;
				4: size_pick = 2;
				default: begin
					size_pick = $urandom_range(0, 99);
					if (size_pick < 70)
						size_pick = $urandom_range(2, 16);
					else if (size_pick < 85)
						size_pick = $urandom_range(17, 255);
					else
						size_pick = $urandom_range(256, 511);
				end
			endcase
			set_size(size_pick[8:0]);
			steady = (phase % 4 == 3);
			narrow = ($urandom_range(0, 2) == 0);
			budget = (span > 64) ? 50 : 150;
			repeat (budget) begin
				random_request();
				done_random++;
			end
			phase++;
		end

		drain(300);
		$display("Sent %0d palette writes and %0d queries over %0d palette_size settings.",
			n_writes, n_queries, n_settings);
		$display("Searches ran empty, single, tied, exact-hit and saturated, with stalls.");
		if (errors == 0 && pending == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
